[rtl/tsa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_pkg
// Types, codes and sizes shared by the touch panel sequencer modules.
// ----------------------------------------------------------------------------
package tsa_pkg;

  // Averaging depth: 2**LOG2_SAMPLES conversions make one report.
  localparam int LOG2_SAMPLES = 4;
  localparam int SAMPLE_W     = 10;
  localparam int SUM_W        = SAMPLE_W + LOG2_SAMPLES;
  localparam int COUNT_W      = LOG2_SAMPLES + 1;
  localparam logic [COUNT_W-1:0] SAMPLES = COUNT_W'(1 << LOG2_SAMPLES);

  // Stream widths; the data widths are padded to whole bytes.
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;

  // Request kinds carried in the input tuser.
  typedef enum logic [1:0] {
    KIND_IRQ  = 2'd0,
    KIND_TICK = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  // Panel sequencer states, one-hot.
  typedef enum logic [2:0] {
    MODE_WAIT_DOWN = 3'b001,
    MODE_WAIT_UP   = 3'b010,
    MODE_AUTO      = 3'b100
  } mode_t;

  // Panel mode codes as reported on the output.
  localparam logic [1:0] PMODE_WAIT_DOWN = 2'd0;
  localparam logic [1:0] PMODE_WAIT_UP   = 2'd1;
  localparam logic [1:0] PMODE_AUTO      = 2'd2;

  typedef struct packed {
    kind_t               kind;
    logic                touch_change_pending;
    logic                conversion_done_pending;
    logic                pen_is_up;
    logic [SAMPLE_W-1:0] x_sample;
    logic [SAMPLE_W-1:0] y_sample;
  } item_t;

  typedef struct packed {
    logic [1:0]          panel_mode;
    logic                start_conversion;
    logic                read_valid;
    logic [SAMPLE_W-1:0] read_x;
    logic [SAMPLE_W-1:0] read_y;
    logic                read_pressure;
  } result_t;

  // Encode the one-hot state into the reported mode code.
  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] code;
    unique case (m)
      MODE_WAIT_DOWN: code = PMODE_WAIT_DOWN;
      MODE_WAIT_UP:   code = PMODE_WAIT_UP;
      MODE_AUTO:      code = PMODE_AUTO;
      default:        code = PMODE_WAIT_DOWN;
    endcase
    return code;
  endfunction

endpackage

[rtl/tsa_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_core
// Panel state, sample accumulators and report mailbox; applies one request
// per enabled cycle and produces its result combinationally.
// ----------------------------------------------------------------------------
module tsa_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  tsa_pkg::item_t    item,
  output tsa_pkg::result_t  result
);

  tsa_pkg::mode_t                     mode, mode_next;
  logic [tsa_pkg::COUNT_W-1:0]        count, count_next;
  logic [tsa_pkg::SUM_W-1:0]          x_sum, x_sum_next;
  logic [tsa_pkg::SUM_W-1:0]          y_sum, y_sum_next;
  logic                               tick_en, tick_en_next;
  logic                               mb_full, mb_full_next;
  logic [tsa_pkg::SAMPLE_W-1:0]       mb_x, mb_x_next;
  logic [tsa_pkg::SAMPLE_W-1:0]       mb_y, mb_y_next;
  logic                               mb_p, mb_p_next;

  logic [tsa_pkg::COUNT_W-1:0]        count_inc;
  logic [tsa_pkg::SUM_W-1:0]          x_acc, y_acc;
  logic                               start;
  logic                               rd_valid;
  logic [tsa_pkg::SAMPLE_W-1:0]       rd_x, rd_y;
  logic                               rd_p;

  // Accumulated values if this request carries a pen-down sample.
  assign count_inc = count + tsa_pkg::COUNT_W'(1);
  assign x_acc     = x_sum + tsa_pkg::SUM_W'(item.x_sample);
  assign y_acc     = y_sum + tsa_pkg::SUM_W'(item.y_sample);

  // Next state and result for the current request. A post only lands in an
  // empty mailbox; later posts in the same request see the updated flag.
  always_comb begin
    mode_next    = mode;
    count_next   = count;
    x_sum_next   = x_sum;
    y_sum_next   = y_sum;
    tick_en_next = tick_en;
    mb_full_next = mb_full;
    mb_x_next    = mb_x;
    mb_y_next    = mb_y;
    mb_p_next    = mb_p;
    start        = 1'b0;
    rd_valid     = 1'b0;
    rd_x         = '0;
    rd_y         = '0;
    rd_p         = 1'b0;

    unique case (item.kind)
      tsa_pkg::KIND_IRQ: begin
        // Touch change is handled before conversion done.
        if (item.touch_change_pending) begin
          if (item.pen_is_up) begin
            mode_next = tsa_pkg::MODE_WAIT_DOWN;
            if (!mb_full_next) begin
              mb_x_next    = '0;
              mb_y_next    = '0;
              mb_p_next    = 1'b0;
              mb_full_next = 1'b1;
            end
          end else begin
            mode_next = tsa_pkg::MODE_AUTO;
            start     = 1'b1;
          end
        end
        if (item.conversion_done_pending) begin
          if (!item.pen_is_up) begin
            if (count_inc >= tsa_pkg::SAMPLES) begin
              // Full set of samples: post the averages.
              if (!mb_full_next) begin
                mb_x_next    = x_acc[tsa_pkg::SUM_W-1:tsa_pkg::LOG2_SAMPLES];
                mb_y_next    = y_acc[tsa_pkg::SUM_W-1:tsa_pkg::LOG2_SAMPLES];
                mb_p_next    = 1'b1;
                mb_full_next = 1'b1;
              end
              count_next   = '0;
              x_sum_next   = '0;
              y_sum_next   = '0;
              mode_next    = tsa_pkg::MODE_WAIT_UP;
              tick_en_next = 1'b1;
            end else begin
              count_next = count_inc;
              x_sum_next = x_acc;
              y_sum_next = y_acc;
              mode_next  = tsa_pkg::MODE_AUTO;
              start      = 1'b1;
            end
          end else begin
            // Pen lifted during measurement: drop the partial sums.
            count_next   = '0;
            x_sum_next   = '0;
            y_sum_next   = '0;
            tick_en_next = 1'b0;
            mode_next    = tsa_pkg::MODE_WAIT_DOWN;
            if (!mb_full_next) begin
              mb_x_next    = '0;
              mb_y_next    = '0;
              mb_p_next    = 1'b0;
              mb_full_next = 1'b1;
            end
          end
        end
      end
      tsa_pkg::KIND_TICK: begin
        // Periodic recheck of the pen while not measuring.
        if (tick_en && (mode != tsa_pkg::MODE_AUTO)) begin
          if (item.pen_is_up) begin
            tick_en_next = 1'b0;
            mode_next    = tsa_pkg::MODE_WAIT_DOWN;
            if (!mb_full) begin
              mb_x_next    = '0;
              mb_y_next    = '0;
              mb_p_next    = 1'b0;
              mb_full_next = 1'b1;
            end
          end else begin
            mode_next = tsa_pkg::MODE_AUTO;
            start     = 1'b1;
          end
        end
      end
      tsa_pkg::KIND_READ: begin
        // Take the report if there is one; never waits.
        if (mb_full) begin
          rd_valid     = 1'b1;
          rd_x         = mb_x;
          rd_y         = mb_y;
          rd_p         = mb_p;
          mb_full_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Result of the current request.
  always_comb begin
    result.panel_mode       = tsa_pkg::mode_code(mode_next);
    result.start_conversion = start;
    result.read_valid       = rd_valid;
    result.read_x           = rd_x;
    result.read_y           = rd_y;
    result.read_pressure    = rd_p;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= tsa_pkg::MODE_WAIT_DOWN;
      count   <= '0;
      x_sum   <= '0;
      y_sum   <= '0;
      tick_en <= 1'b0;
      mb_full <= 1'b0;
      mb_x    <= '0;
      mb_y    <= '0;
      mb_p    <= 1'b0;
    end else if (fire) begin
      mode    <= mode_next;
      count   <= count_next;
      x_sum   <= x_sum_next;
      y_sum   <= y_sum_next;
      tick_en <= tick_en_next;
      mb_full <= mb_full_next;
      mb_x    <= mb_x_next;
      mb_y    <= mb_y_next;
      mb_p    <= mb_p_next;
    end
  end

endmodule

[rtl/touch_sample_average_fsm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_sample_average_fsm
// Resistive touch panel sequencer with 16-sample averaging and a one-slot
// report mailbox.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the s_ stream: s_tuser gives the kind (interrupt, timer
// tick or read) and s_tdata carries the interrupt flags, the pen bit and the
// raw x and y samples. Every request produces exactly one result on the m_
// stream: the panel mode after the request, the conversion start pulse and,
// for a read, the mailbox report (all zero when the mailbox was empty).
// A request is registered on entry, then applied to the panel state as it
// leaves the entry register, and its result is written to the output
// register, which drives m_tvalid. One request is taken per cycle while
// the output is not stalled; the rate is set by the state update in the
// core, which applies one request per enabled cycle.
// When the receiver holds m_tready low, the result stays in the output
// register, the entry register still takes one more request, and s_tready
// then drops until the output drains. Reset clears the panel to wait for
// pen down, empties the sums and mailbox and drops any request in flight.
// ----------------------------------------------------------------------------
module touch_sample_average_fsm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [0] touch_change_pending, [1] conversion_done_pending, [2] pen_is_up,
  // [12:3] x_sample, [22:13] y_sample, [23] zero
  input  logic [tsa_pkg::IN_DATA_W-1:0]  s_tdata,
  // [1:0] kind
  input  logic [tsa_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [1:0] panel_mode, [2] start_conversion, [3] read_valid, [13:4] read_x,
  // [23:14] read_y, [24] read_pressure, [31:25] zero
  output logic [tsa_pkg::OUT_DATA_W-1:0] m_tdata
);

  logic              in_valid;
  tsa_pkg::item_t    in_item;
  logic              out_valid;
  tsa_pkg::result_t  out_result;
  tsa_pkg::result_t  core_result;
  logic              advance;

  // A request moves on when the output register is free or being drained.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Entry register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.kind                    <= tsa_pkg::kind_t'(s_tuser);
      in_item.touch_change_pending    <= s_tdata[0];
      in_item.conversion_done_pending <= s_tdata[1];
      in_item.pen_is_up               <= s_tdata[2];
      in_item.x_sample                <= s_tdata[12:3];
      in_item.y_sample                <= s_tdata[22:13];
    end
  end

  // Panel state and step logic.
  tsa_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_item),
    .result (core_result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0,
                     out_result.read_pressure,
                     out_result.read_y,
                     out_result.read_x,
                     out_result.read_valid,
                     out_result.start_conversion,
                     out_result.panel_mode};

endmodule

[tb/touch_panel_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_panel_checker
// Watches both streams of the touch panel sequencer, keeps its own copy of
// the panel state and mailbox, works out the result of every accepted
// request and compares it with what the sequencer returns, in order.
// ----------------------------------------------------------------------------
module touch_panel_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  // [0] touch_change_pending, [1] conversion_done_pending, [2] pen_is_up,
  // [12:3] x_sample, [22:13] y_sample, [23] zero
  input  logic [tsa_pkg::IN_DATA_W-1:0]  s_tdata,
  // [1:0] kind
  input  logic [tsa_pkg::IN_USER_W-1:0]  s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // [1:0] panel_mode, [2] start_conversion, [3] read_valid, [13:4] read_x,
  // [23:14] read_y, [24] read_pressure, [31:25] zero
  input  logic [tsa_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                             mismatches,
  output int                             outstanding
);
  import tsa_pkg::*;

  // Shadow copy of the panel state.
  logic [1:0]          panel_mode_now;
  logic [COUNT_W-1:0]  conv_count;
  logic [SUM_W-1:0]    x_total;
  logic [SUM_W-1:0]    y_total;
  logic                tick_armed;
  logic                slot_full;
  logic [SAMPLE_W-1:0] slot_x;
  logic [SAMPLE_W-1:0] slot_y;
  logic                slot_pressure;

  result_t pending_reports[$];
  int      fail_count = 0;

  // A report only lands in the mailbox when the slot is empty.
  task automatic post_to_slot(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y,
                              input logic p);
    if (!slot_full) begin
      slot_x        = x;
      slot_y        = y;
      slot_pressure = p;
      slot_full     = 1'b1;
    end
  endtask

  task automatic clear_totals();
    conv_count = '0;
    x_total    = '0;
    y_total    = '0;
  endtask

  // Applies one request to the shadow state and returns the result it causes.
  task automatic advance_panel(input item_t req, output result_t res);
    res = '0;
    case (req.kind)
      KIND_IRQ: begin
        // Touch change is handled before conversion done.
        if (req.touch_change_pending) begin
          if (req.pen_is_up) begin
            panel_mode_now = PMODE_WAIT_DOWN;
            post_to_slot('0, '0, 1'b0);
          end else begin
            panel_mode_now       = PMODE_AUTO;
            res.start_conversion = 1'b1;
          end
        end
        if (req.conversion_done_pending) begin
          if (!req.pen_is_up) begin
            conv_count = conv_count + 1'b1;
            x_total    = x_total + SUM_W'(req.x_sample);
            y_total    = y_total + SUM_W'(req.y_sample);
            if (conv_count >= SAMPLES) begin
              post_to_slot(SAMPLE_W'(x_total >> LOG2_SAMPLES),
                           SAMPLE_W'(y_total >> LOG2_SAMPLES), 1'b1);
              clear_totals();
              panel_mode_now = PMODE_WAIT_UP;
              tick_armed     = 1'b1;
            end else begin
              panel_mode_now       = PMODE_AUTO;
              res.start_conversion = 1'b1;
            end
          end else begin
            clear_totals();
            tick_armed     = 1'b0;
            panel_mode_now = PMODE_WAIT_DOWN;
            post_to_slot('0, '0, 1'b0);
          end
        end
      end
      KIND_TICK: begin
        // The tick only rechecks the pen outside of a measurement.
        if (tick_armed && panel_mode_now != PMODE_AUTO) begin
          if (req.pen_is_up) begin
            tick_armed     = 1'b0;
            panel_mode_now = PMODE_WAIT_DOWN;
            post_to_slot('0, '0, 1'b0);
          end else begin
            panel_mode_now       = PMODE_AUTO;
            res.start_conversion = 1'b1;
          end
        end
      end
      KIND_READ: begin
        if (slot_full) begin
          res.read_valid    = 1'b1;
          res.read_x        = slot_x;
          res.read_y        = slot_y;
          res.read_pressure = slot_pressure;
          slot_full         = 1'b0;
        end
      end
      default: ;
    endcase
    res.panel_mode = panel_mode_now;
  endtask

  // Results are checked before requests are taken so that a result and a
  // request in the same cycle never see each other's queue entry.
  always @(posedge clk) begin : monitor
    item_t   req;
    result_t want;
    result_t got;
    if (rst) begin
      panel_mode_now = PMODE_WAIT_DOWN;
      clear_totals();
      tick_armed    = 1'b0;
      slot_full     = 1'b0;
      slot_x        = '0;
      slot_y        = '0;
      slot_pressure = 1'b0;
      pending_reports.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.panel_mode       = m_tdata[1:0];
        got.start_conversion = m_tdata[2];
        got.read_valid       = m_tdata[3];
        got.read_x           = m_tdata[13:4];
        got.read_y           = m_tdata[23:14];
        got.read_pressure    = m_tdata[24];
        if (pending_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with no request waiting: %h", $realtime, m_tdata);
        end else begin
          want = pending_reports.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: result mismatch, expected mode %0d start %0b valid %0b ",
                       $realtime, want.panel_mode, want.start_conversion,
                       want.read_valid,
                       "x %0d y %0d p %0b, ",
                       want.read_x, want.read_y, want.read_pressure,
                       "got mode %0d start %0b valid %0b ",
                       got.panel_mode, got.start_conversion, got.read_valid,
                       "x %0d y %0d p %0b",
                       got.read_x, got.read_y, got.read_pressure);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        req.kind                    = kind_t'(s_tuser);
        req.touch_change_pending    = s_tdata[0];
        req.conversion_done_pending = s_tdata[1];
        req.pen_is_up               = s_tdata[2];
        req.x_sample                = s_tdata[12:3];
        req.y_sample                = s_tdata[22:13];
        advance_panel(req, want);
        pending_reports.push_back(want);
      end
    end
    outstanding <= pending_reports.size();
    mismatches  <= fail_count;
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the touch panel sequencer with directed corner requests followed by
// random touch gestures and noise, with random gaps on the request side and
// random stalls on the result side. The checker beside the sequencer
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import tsa_pkg::*;

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [IN_USER_W-1:0]  s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  int                    mismatches;
  int                    outstanding;

  // Odds of a gap or stall burst; zero means none.
  int gap_odds   = 0;
  int stall_odds = 0;
  int sent_count = 0;

  touch_sample_average_fsm i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  touch_panel_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the sequencer hangs.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // The result side stalls in bursts of random length.
  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold != 0)
        hold--;
      else if (rst == 1'b0 && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
        hold = $urandom_range(1, 9);
      m_tready <= (hold == 0);
    end
  end

  // Sends one request and returns at the edge where it is taken.
  task automatic send_request(input kind_t kind, input logic tc, input logic done,
                              input logic up, input logic [SAMPLE_W-1:0] x,
                              input logic [SAMPLE_W-1:0] y);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {1'b0, y, x, up, done, tc};
    do @(posedge clk); while (!s_tready);
    sent_count++;
  endtask

  // Samples lean toward the ends of the range.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic send_read();
    send_request(KIND_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), pick_sample(), pick_sample());
  endtask

  // One touch: pen down, one or more averaging rounds restarted by the timer,
  // then a release through one of the three paths or a lift during a round.
  task automatic run_gesture();
    int  rounds;
    bit  lifted;
    rounds = $urandom_range(1, 3);
    lifted = 1'b0;
    send_request(KIND_IRQ, 1'b1, $urandom_range(0, 3) == 0, 1'b0,
                 pick_sample(), pick_sample());
    for (int r = 0; r < rounds && !lifted; r++) begin
      for (int i = 0; i < 16 && !lifted; i++) begin
        if ($urandom_range(0, 7) == 0)
          send_read();
        if ($urandom_range(0, 49) == 0) begin
          send_request(KIND_IRQ, 1'b0, 1'b1, 1'b1, pick_sample(), pick_sample());
          lifted = 1'b1;
        end else begin
          send_request(KIND_IRQ, 1'b0, 1'b1, 1'b0, pick_sample(), pick_sample());
        end
      end
      if (!lifted) begin
        if ($urandom_range(0, 1) == 0)
          send_read();
        if (r < rounds - 1) begin
          send_request(KIND_TICK, 1'b0, 1'b0, 1'b0, pick_sample(), pick_sample());
          // A tick during a measurement is ignored.
          if ($urandom_range(0, 3) == 0)
            send_request(KIND_TICK, 1'b0, 1'b0, 1'($urandom_range(0, 1)),
                         pick_sample(), pick_sample());
        end
      end
    end
    if (!lifted) begin
      case ($urandom_range(0, 2))
        0: send_request(KIND_TICK, 1'b0, 1'b0, 1'b1, pick_sample(), pick_sample());
        1: send_request(KIND_IRQ, 1'b1, 1'b0, 1'b1, pick_sample(), pick_sample());
        default: send_request(KIND_IRQ, 1'b0, 1'b1, 1'b1, pick_sample(), pick_sample());
      endcase
    end
    send_read();
  endtask

  // Fully random requests, including the unused kind.
  task automatic run_noise();
    repeat ($urandom_range(1, 10))
      send_request(kind_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   SAMPLE_W'($urandom_range(0, 1023)), SAMPLE_W'($urandom_range(0, 1023)));
  endtask

  // Directed corners: empty reads, ignored requests, both flags together,
  // release reports, and a report dropped while the mailbox is full.
  task automatic run_directed();
    send_request(KIND_READ, 1'b0, 1'b0, 1'b0, '0, '0);
    send_request(KIND_NONE, 1'b1, 1'b1, 1'b1, '1, '1);
    send_request(KIND_IRQ, 1'b0, 1'b0, 1'b1, '1, '1);
    send_request(KIND_TICK, 1'b0, 1'b0, 1'b0, '0, '0);
    send_request(KIND_IRQ, 1'b1, 1'b0, 1'b0, '0, '0);
    send_request(KIND_IRQ, 1'b0, 1'b1, 1'b0, '1, '0);
    send_request(KIND_IRQ, 1'b0, 1'b1, 1'b0, '0, '1);
    send_request(KIND_IRQ, 1'b1, 1'b1, 1'b0, '1, '1);
    send_request(KIND_READ, 1'b1, 1'b1, 1'b1, '1, '1);
    send_request(KIND_IRQ, 1'b1, 1'b1, 1'b1, '1, '1);
    send_request(KIND_READ, 1'b0, 1'b0, 1'b0, '0, '0);
    send_request(KIND_IRQ, 1'b1, 1'b0, 1'b1, '0, '0);
    send_request(KIND_IRQ, 1'b1, 1'b0, 1'b1, '0, '0);
    send_request(KIND_READ, 1'b0, 1'b0, 1'b0, '0, '0);
    send_request(KIND_READ, 1'b0, 1'b0, 1'b0, '0, '0);
    send_request(KIND_TICK, 1'b0, 1'b0, 1'b1, '1, '1);
    send_request(KIND_IRQ, 1'b0, 1'b1, 1'b1, '1, '1);
    send_request(KIND_READ, 1'b0, 1'b0, 1'b0, '0, '0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_odds   = 4;
    stall_odds = 4;
    run_directed();

    // Let the pipeline drain completely before carrying on.
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);

    while (sent_count < 800) begin
      if (sent_count >= 700) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       begin gap_odds = 0; stall_odds = 0; end
          1:       begin gap_odds = 3; stall_odds = 3; end
          default: begin gap_odds = 8; stall_odds = 6; end
        endcase
      end
      if ($urandom_range(0, 9) < 7)
        run_gesture();
      else
        run_noise();
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
